// ----- sv/bafl_pkg.sv -----
// ----------------------------------------------------------------------------
// Box average filter package
// Shared types and constants for the box average filter.
// ----------------------------------------------------------------------------
package bafl_pkg;

    localparam int PIX_W      = 8;
    localparam int PIX_MAX    = 255;
    localparam int ROW_W      = 16;
    localparam int CFG_WID_W  = 12;
    localparam int CFG_RAD_W  = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_WID_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [ROW_W-1:0]     RST_HEIGHT = 16'd480;
    localparam logic [CFG_RAD_W-1:0] RST_RADIUS = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 8'd0,
        REG_IMAGE_HEIGHT = 8'd1,
        REG_RADIUS_ROWS  = 8'd2,
        REG_RADIUS_COLS  = 8'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_ACC,
        ST_FEED,
        ST_WAIT
    } seq_state_t;

    typedef struct packed {
        logic accept_ok;
        logic setup;
        logic read;
        logic feed;
    } seq_ctrl_t;

endpackage

// ----- sv/bafl_line_store.sv -----
// ----------------------------------------------------------------------------
// Line store
// Single-port-write, single-port-read pixel memory with registered read data.
// ----------------------------------------------------------------------------
module bafl_line_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [bafl_pkg::PIX_W-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output logic [bafl_pkg::PIX_W-1:0] rd_data
);
    import bafl_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/bafl_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step; settles one quotient bit and passes the
// partial remainder to the next cell.
// ----------------------------------------------------------------------------
module bafl_div_cell #(
    parameter int BIT   = 7,
    parameter int SUM_W = 14,
    parameter int CNT_W = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       in_vld,
    input  logic                       in_last,
    input  logic [SUM_W-1:0]           in_rem,
    input  logic [CNT_W-1:0]           in_div,
    input  logic [bafl_pkg::PIX_W-1:0] in_quo,
    output logic                       out_vld,
    output logic                       out_last,
    output logic [SUM_W-1:0]           out_rem,
    output logic [CNT_W-1:0]           out_div,
    output logic [bafl_pkg::PIX_W-1:0] out_quo
);
    import bafl_pkg::*;

    localparam int XW = SUM_W + PIX_W;

    logic [XW-1:0]    div_sh;
    logic [XW-1:0]    rem_x;
    logic             fits;
    logic [SUM_W-1:0] rem_next;
    logic [PIX_W-1:0] quo_next;
    logic             vld_reg;
    logic             last_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [CNT_W-1:0] div_reg;
    logic [PIX_W-1:0] quo_reg;

    always_comb
    begin
        div_sh   = XW'(in_div) << BIT;
        rem_x    = XW'(in_rem);
        fits     = (rem_x >= div_sh);
        rem_next = fits ? SUM_W'(rem_x - div_sh) : in_rem;
        quo_next = in_quo | (PIX_W'(fits) << BIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            last_reg <= in_last;
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            quo_reg  <= quo_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_last = last_reg;
    assign out_rem  = rem_reg;
    assign out_div  = div_reg;
    assign out_quo  = quo_reg;

endmodule

// ----- sv/box_average_filter.sv -----
// ----------------------------------------------------------------------------
// Box average filter
// Truncated mean over a clipped rectangular window of one 8-bit image channel.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order; tuser set marks a drain
// item sent after the frame to release the results still owed. Results leave
// on m_axis in raster order, radius_rows rows and radius_cols columns behind
// the input, with tlast on the final result of the frame.
// For an item that produces a result, the window of in-frame pixels (at most
// 49 with the default radius) is read from the line store one pixel per
// cycle over its single read port, then the mean is formed by a chain of
// eight divider cells, each settling one bit of the quotient and handing on
// every cycle unless the chain stalls. Only one item is worked on at a time;
// the next is accepted as soon as the result has moved into the output
// register, even if the receiver has not yet taken it. While the receiver
// stalls, a finished mean waits at the end of the divider chain and the block
// accepts nothing further. Configuration writes to a defined register restart
// the frame; the user must make them only while idle, as the block does not
// enforce it. After reset the registers hold 640 x 480 with radius 3 in both
// directions and the frame starts from the top left; no clearing pass is
// needed, as only line store entries written in the current frame are ever
// read.
// ----------------------------------------------------------------------------
module box_average_filter #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input channel. tdata: pixel[7:0]. tuser: operation[0].
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bafl_pkg::PIX_W-1:0]     s_axis_tdata,
    input  logic                           s_axis_tuser,
    // Output channel. tdata: average[7:0]. tlast: last_of_frame.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bafl_pkg::PIX_W-1:0]     m_axis_tdata,
    output logic                           m_axis_tlast,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bafl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bafl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bafl_pkg::*;

    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int RGW   = $clog2(RING);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int RLW   = $clog2(2 * MAX_RADIUS + 1);
    localparam int WIN   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNTW  = $clog2(WIN + 1);
    localparam int SUMW  = $clog2(WIN * PIX_MAX + 1);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = ROW_W + CW;

    // Configuration registers.
    logic [CFG_WID_W-1:0] width_reg;
    logic [ROW_W-1:0]     height_reg;
    logic [CFG_RAD_W-1:0] rad_row_reg;
    logic [CFG_RAD_W-1:0] rad_col_reg;
    logic                 cfg_wr;
    logic                 cfg_hit;

    // Effective geometry after clamping.
    logic [CW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [RW-1:0]    rr_eff;
    logic [RW-1:0]    rc_eff;
    logic [PW-1:0]    lag;

    // Position counters.
    logic [ROW_W-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0]    in_col_reg,  in_col_next;
    logic [RGW-1:0]   in_ring_reg, in_ring_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [CW-1:0]    out_col_reg, out_col_next;
    logic [RGW-1:0]   out_ring_reg, out_ring_next;
    logic [PW-1:0]    pend_reg,    pend_next;

    // Sequencer.
    seq_state_t state_reg, state_next;
    seq_ctrl_t  ctrl;
    logic       in_acc;
    logic       in_done;
    logic       push_ok;
    logic       emit;
    logic       last_pos;

    // Window walk.
    logic [RGW-1:0]   cur_ring_reg, cur_ring_next;
    logic [CW-1:0]    cur_col_reg,  cur_col_next;
    logic [RLW-1:0]   rows_left_reg, rows_left_next;
    logic [CW-1:0]    c0_reg, c0_next;
    logic [CW-1:0]    c1_reg, c1_next;
    logic             last_issue;
    logic             rd_vld_reg;
    logic [SUMW-1:0]  sum_reg;
    logic [CNTW-1:0]  cnt_reg;

    // Line store ports.
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [PIX_W-1:0] rd_data;

    // Divider chain.
    logic             c_vld  [PIX_W+1];
    logic             c_last [PIX_W+1];
    logic [SUMW-1:0]  c_rem  [PIX_W+1];
    logic [CNTW-1:0]  c_div  [PIX_W+1];
    logic [PIX_W-1:0] c_quo  [PIX_W+1];
    logic             advance;
    logic             out_load;

    // Output register.
    logic             out_vld_reg;
    logic [PIX_W-1:0] out_avg_reg;
    logic             out_last_reg;

    // ------------------------------------------------------------------
    // Configuration.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        unique case (cfg_index)
            REG_IMAGE_WIDTH:  cfg_hit = 1'b1;
            REG_IMAGE_HEIGHT: cfg_hit = 1'b1;
            REG_RADIUS_ROWS:  cfg_hit = 1'b1;
            REG_RADIUS_COLS:  cfg_hit = 1'b1;
            default:          cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
            rad_row_reg <= RST_RADIUS;
            rad_col_reg <= RST_RADIUS;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg   <= cfg_data[CFG_WID_W-1:0];
                REG_IMAGE_HEIGHT: height_reg  <= cfg_data[ROW_W-1:0];
                REG_RADIUS_ROWS:  rad_row_reg <= cfg_data[CFG_RAD_W-1:0];
                REG_RADIUS_COLS:  rad_col_reg <= cfg_data[CFG_RAD_W-1:0];
                default:          ;
            endcase
        end
    end

    // A zero size counts as one; the width and radii saturate at what the
    // storage was built for.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(width_reg);
        end
        h_eff  = (height_reg == '0) ? ROW_W'(1) : height_reg;
        rr_eff = (32'(rad_row_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_row_reg);
        rc_eff = (32'(rad_col_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_col_reg);
        lag    = PW'(rr_eff) * PW'(w_eff) + PW'(rc_eff);
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_done = (in_row_reg >= h_eff);
    assign push_ok = in_acc && !s_axis_tuser && !in_done;

    // The gap between items pushed and results given decides whether this
    // push completes a window. Once the frame is fully in, any item drains.
    always_comb
    begin
        if (push_ok)
        begin
            emit = ((pend_reg + PW'(1)) > lag);
        end
        else
        begin
            emit = in_acc && in_done;
        end
    end

    assign last_issue = (cur_col_reg == c1_reg) && (rows_left_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (emit) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_READ;
            ST_READ:  if (last_issue) state_next = ST_ACC;
            ST_ACC:   state_next = ST_FEED;
            ST_FEED:  state_next = ST_WAIT;
            ST_WAIT:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:  ctrl.accept_ok = 1'b1;
            ST_SETUP: ctrl.setup     = 1'b1;
            ST_READ:  ctrl.read      = 1'b1;
            ST_FEED:  ctrl.feed      = 1'b1;
            default:  ;
        endcase
    end

    assign s_axis_tready = ctrl.accept_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Position counters. A write to a defined configuration register or the
    // final result of the frame returns them all to the start.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [CW:0]    col_inc;
        logic [ROW_W:0] row_inc;
        logic           wrap;

        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_ring_next  = in_ring_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_ring_next = out_ring_reg;
        pend_next     = pend_reg;
        last_pos      = 1'b0;
        col_inc       = '0;
        row_inc       = '0;
        wrap          = 1'b0;

        if (cfg_wr && cfg_hit)
        begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_ring_next  = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            out_ring_next = '0;
            pend_next     = '0;
        end
        else if (ctrl.feed)
        begin
            col_inc  = (CW + 1)'(out_col_reg) + (CW + 1)'(1);
            row_inc  = (ROW_W + 1)'(out_row_reg) + (ROW_W + 1)'(1);
            wrap     = (col_inc >= (CW + 1)'(w_eff));
            last_pos = wrap && (row_inc >= (ROW_W + 1)'(h_eff));
            if (last_pos)
            begin
                in_row_next   = '0;
                in_col_next   = '0;
                in_ring_next  = '0;
                out_row_next  = '0;
                out_col_next  = '0;
                out_ring_next = '0;
                pend_next     = '0;
            end
            else if (wrap)
            begin
                out_col_next  = '0;
                out_row_next  = row_inc[ROW_W-1:0];
                out_ring_next = (out_ring_reg == RGW'(RING - 1)) ? '0
                                                                 : out_ring_reg + RGW'(1);
            end
            else
            begin
                out_col_next = col_inc[CW-1:0];
            end
        end
        else if (in_acc)
        begin
            if (push_ok)
            begin
                col_inc = (CW + 1)'(in_col_reg) + (CW + 1)'(1);
                if (col_inc >= (CW + 1)'(w_eff))
                begin
                    in_col_next  = '0;
                    in_row_next  = in_row_reg + ROW_W'(1);
                    in_ring_next = (in_ring_reg == RGW'(RING - 1)) ? '0
                                                                   : in_ring_reg + RGW'(1);
                end
                else
                begin
                    in_col_next = col_inc[CW-1:0];
                end
            end
            if (push_ok && !emit)
            begin
                pend_next = pend_reg + PW'(1);
            end
            else if (!push_ok && emit)
            begin
                pend_next = pend_reg - PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_ring_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_ring_reg <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_ring_reg  <= in_ring_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_ring_reg <= out_ring_next;
            pend_reg     <= pend_next;
        end
    end

    // ------------------------------------------------------------------
    // Window walk: clip the window to the frame, then read it row by row.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [ROW_W:0]  r_hi;
        logic [ROW_W:0]  r_top;
        logic [ROW_W:0]  r_lo;
        logic [RW-1:0]   up;
        logic [RGW:0]    ring_sum;
        logic [CW:0]     c_hi;

        cur_ring_next  = cur_ring_reg;
        cur_col_next   = cur_col_reg;
        rows_left_next = rows_left_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        r_hi           = (ROW_W + 1)'(out_row_reg) + (ROW_W + 1)'(rr_eff);
        r_top          = (r_hi >= (ROW_W + 1)'(h_eff)) ? (ROW_W + 1)'(h_eff) - (ROW_W + 1)'(1)
                                                       : r_hi;
        up             = (out_row_reg > ROW_W'(rr_eff)) ? rr_eff : RW'(out_row_reg);
        r_lo           = (ROW_W + 1)'(out_row_reg) - (ROW_W + 1)'(up);
        ring_sum       = (RGW + 1)'(out_ring_reg) + (RGW + 1)'(RING) - (RGW + 1)'(up);
        c_hi           = (CW + 1)'(out_col_reg) + (CW + 1)'(rc_eff);

        if (ctrl.setup)
        begin
            rows_left_next = RLW'(r_top - r_lo);
            cur_ring_next  = (out_ring_reg >= RGW'(up)) ? out_ring_reg - RGW'(up)
                                                         : RGW'(ring_sum);
            c0_next        = (out_col_reg > CW'(rc_eff)) ? out_col_reg - CW'(rc_eff) : '0;
            c1_next        = (c_hi >= (CW + 1)'(w_eff)) ? w_eff - CW'(1) : c_hi[CW-1:0];
            cur_col_next   = c0_next;
        end
        else if (ctrl.read)
        begin
            if (cur_col_reg == c1_reg)
            begin
                cur_col_next   = c0_reg;
                rows_left_next = rows_left_reg - RLW'(1);
                cur_ring_next  = (cur_ring_reg == RGW'(RING - 1)) ? '0
                                                                  : cur_ring_reg + RGW'(1);
            end
            else
            begin
                cur_col_next = cur_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_ring_reg  <= cur_ring_next;
        cur_col_reg   <= cur_col_next;
        rows_left_reg <= rows_left_next;
        c0_reg        <= c0_next;
        c1_reg        <= c1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= ctrl.read;
        end
    end

    // Sum and count of the pixels read, one per cycle behind the reads.
    always_ff @(posedge clk)
    begin
        if (ctrl.setup)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            sum_reg <= sum_reg + SUMW'(rd_data);
            cnt_reg <= cnt_reg + CNTW'(1);
        end
    end

    assign wr_addr = AW'(in_ring_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign rd_addr = AW'(cur_ring_reg) * AW'(MAX_WIDTH) + AW'(cur_col_reg);

    bafl_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (push_ok),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (ctrl.read),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Divider chain: cell k settles quotient bit PIX_W-1-k. The chain only
    // stalls when a finished mean finds the output register still full.
    // ------------------------------------------------------------------
    assign advance  = !(c_vld[PIX_W] && out_vld_reg && !m_axis_tready);
    assign out_load = advance && c_vld[PIX_W];

    assign c_vld[0]  = ctrl.feed;
    assign c_last[0] = last_pos;
    assign c_rem[0]  = sum_reg;
    assign c_div[0]  = cnt_reg;
    assign c_quo[0]  = '0;

    for (genvar k = 0; k < PIX_W; k++)
    begin : g_cell
        bafl_div_cell #(
            .BIT   (PIX_W - 1 - k),
            .SUM_W (SUMW),
            .CNT_W (CNTW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_vld   (c_vld[k]),
            .in_last  (c_last[k]),
            .in_rem   (c_rem[k]),
            .in_div   (c_div[k]),
            .in_quo   (c_quo[k]),
            .out_vld  (c_vld[k+1]),
            .out_last (c_last[k+1]),
            .out_rem  (c_rem[k+1]),
            .out_div  (c_div[k+1]),
            .out_quo  (c_quo[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_avg_reg  <= c_quo[PIX_W];
            out_last_reg <= c_last[PIX_W];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_avg_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- test/box_average_filter_tb.sv -----
// ----------------------------------------------------------------------------
// Box average filter testbench
// Streams small frames under many window and frame settings, predicts every
// windowed mean in the testbench and compares each result as it leaves.
// ----------------------------------------------------------------------------
// A short directed part covers pixel extremes, drain items sent too early,
// pixels sent after the frame, drain items with nothing owed, and the
// clamping of zero and oversized frame sizes. A random part then runs many
// frames with random content, random settings and a little noise, while both
// the sender and the receiver idle at random.
// ----------------------------------------------------------------------------
module box_average_filter_tb;

    import bafl_pkg::*;

    localparam int RING_ROWS   = 8;
    localparam int MAX_W       = 2048;
    localparam int MAX_RAD     = 3;
    // Cycles the block may still need for one result after its last one left.
    localparam int SETTLE      = 100;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 360;
    localparam int LONG_LINE_W = 160;
    // Indexes that name no register; a write to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] NO_REG_LOW  = 8'h55;
    localparam logic [CFG_IDX_W-1:0] NO_REG_HIGH = 8'hAA;
    localparam bit OP_PIXEL = 1'b0;
    localparam bit OP_DRAIN = 1'b1;

    typedef struct {
        logic [PIX_W-1:0] average;
        logic             last_of_frame;
    } mean_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    box_average_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the block's state, kept in step with accepted items.
    logic [PIX_W-1:0]     shadow_lines [0:RING_ROWS*MAX_W-1];
    logic [CFG_WID_W-1:0] set_width = RST_WIDTH;
    logic [ROW_W-1:0]     set_height = RST_HEIGHT;
    logic [CFG_RAD_W-1:0] set_rad_rows = RST_RADIUS;
    logic [CFG_RAD_W-1:0] set_rad_cols = RST_RADIUS;
    int unsigned          pos_in_row, pos_in_col, pos_out_row, pos_out_col;

    mean_t       owed_means[$];
    int          mismatches = 0;
    int          means_checked = 0;
    int          frames_done = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int          stall_pct = 0;   // receiver stall probability in percent
    int          gap_max = 0;     // longest sender gap, 0 for a steady stream
    int          burst_left = 0;
    bit          valid_held = 1'b0;

    function automatic int unsigned frame_width();
        if (set_width == 0) return 1;
        if (set_width > MAX_W) return MAX_W;
        return set_width;
    endfunction

    function automatic int unsigned frame_height();
        return (set_height == 0) ? 1 : set_height;
    endfunction

    function automatic void restart_frame();
        pos_in_row = 0;
        pos_in_col = 0;
        pos_out_row = 0;
        pos_out_col = 0;
    endfunction

    function automatic void shadow_register(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_IMAGE_WIDTH:  set_width = val[CFG_WID_W-1:0];
            REG_IMAGE_HEIGHT: set_height = val;
            REG_RADIUS_ROWS:  set_rad_rows = val[CFG_RAD_W-1:0];
            REG_RADIUS_COLS:  set_rad_cols = val[CFG_RAD_W-1:0];
            default: return;
        endcase
        restart_frame();
    endfunction

    // Advances the shadow state by one accepted item and queues the mean it
    // releases, if any.
    function automatic void predict_mean(bit op, logic [PIX_W-1:0] pix);
        int unsigned w, h, rr, rc, lag, r0, r1, c0, c1, sum, cnt;
        bit input_done, emit;
        mean_t m;
        w = frame_width();
        h = frame_height();
        rr = set_rad_rows;
        rc = set_rad_cols;
        lag = rr * w + rc;
        input_done = pos_in_row >= h;
        emit = 1'b0;
        if (op == OP_PIXEL && !input_done) begin
            shadow_lines[(pos_in_row % RING_ROWS) * MAX_W + pos_in_col] = pix;
            pos_in_col++;
            if (pos_in_col >= w) begin
                pos_in_col = 0;
                pos_in_row++;
            end
            emit = (pos_in_row * w + pos_in_col) - (pos_out_row * w + pos_out_col) > lag;
        end else if (input_done) begin
            emit = 1'b1;
        end
        if (!emit) return;
        r0 = (pos_out_row > rr) ? pos_out_row - rr : 0;
        r1 = (pos_out_row + rr >= h) ? h - 1 : pos_out_row + rr;
        c0 = (pos_out_col > rc) ? pos_out_col - rc : 0;
        c1 = (pos_out_col + rc >= w) ? w - 1 : pos_out_col + rc;
        sum = 0;
        cnt = 0;
        for (int unsigned r = r0; r <= r1; r++)
            for (int unsigned c = c0; c <= c1; c++) begin
                sum += shadow_lines[(r % RING_ROWS) * MAX_W + c];
                cnt++;
            end
        m.average = PIX_W'(sum / cnt);
        pos_out_col++;
        if (pos_out_col >= w) begin
            pos_out_col = 0;
            pos_out_row++;
        end
        m.last_of_frame = pos_out_row >= h;
        if (m.last_of_frame) begin
            restart_frame();
            frames_done++;
        end
        owed_means.push_back(m);
    endfunction

    // Receiver: checks each accepted mean and then picks its next stall.
    always @(posedge clk) begin
        mean_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (owed_means.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: average %0d last %0b",
                             m_axis_tdata, m_axis_tlast);
            end else begin
                want = owed_means.pop_front();
                means_checked++;
                if (m_axis_tdata !== want.average || m_axis_tlast !== want.last_of_frame) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: average %0d (want %0d) last %0b (want %0b)",
                                 m_axis_tdata, want.average, m_axis_tlast,
                                 want.last_of_frame);
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog for a block that hangs.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results owed", cycle_count,
                     owed_means.size());
            $display("FAIL");
            $finish;
        end
    end

    // Sends one item and waits until it is accepted. If gap_max is set, the
    // sender runs in bursts and drops valid for a random gap after each one.
    task automatic send_item(bit op, logic [PIX_W-1:0] pix);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= pix;
        valid_held = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        predict_mean(op, pix);
        items_sent++;
        if (gap_max > 0) begin
            if (burst_left == 0) begin
                s_axis_tvalid <= 1'b0;
                valid_held = 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
                burst_left = $urandom_range(0, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic stop_sending();
        if (valid_held) s_axis_tvalid <= 1'b0;
        valid_held = 1'b0;
    endtask

    // Lets every owed mean arrive and the block settle.
    task automatic wait_until_drained();
        stop_sending();
        while (owed_means.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        shadow_register(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Writes a full setting; spare upper data bits carry random noise.
    task automatic set_frame(int w, int h, int rr, int rc);
        write_register(REG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), 12'(w)});
        write_register(REG_IMAGE_HEIGHT, 16'(h));
        write_register(REG_RADIUS_ROWS, {14'($urandom_range(0, 16383)), 2'(rr)});
        write_register(REG_RADIUS_COLS, {14'($urandom_range(0, 16383)), 2'(rc)});
    endtask

    // Sends drain items until the frame's last mean has been released.
    task automatic drain_frame(int pixel_pct);
        while (pos_in_row >= frame_height() && pos_in_row != 0)
            send_item(($urandom_range(0, 99) < pixel_pct) ? OP_PIXEL : OP_DRAIN,
                      PIX_W'($urandom));
    endtask

    task automatic test_extremes_and_drain_rules();
        set_frame(3, 3, 1, 1);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_DRAIN, 8'd17);      // too early: ignored
        send_item(OP_PIXEL, 8'd0);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd0);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd0);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd170);
        send_item(OP_DRAIN, 8'd0);
        send_item(OP_PIXEL, 8'd85);      // frame fully in: counts as a drain
        send_item(OP_DRAIN, 8'd255);
        send_item(OP_DRAIN, 8'd0);
        send_item(OP_DRAIN, 8'd0);       // nothing owed: no result
        send_item(OP_DRAIN, 8'd0);
    endtask

    task automatic test_size_clamping();
        // Zero width and height behave as a single pixel frame.
        set_frame(0, 0, 0, 0);
        send_item(OP_PIXEL, 8'd201);
        send_item(OP_PIXEL, 8'd77);
        // Oversized width and the tallest frame: only a few pixels go in,
        // well short of the first result; the next setting restarts it.
        set_frame(4095, 65535, 3, 3);
        repeat (4) send_item(OP_PIXEL, PIX_W'($urandom));
        write_register(NO_REG_LOW, 16'h5555);
        write_register(NO_REG_HIGH, 16'hAAAA);
    endtask

    // One single-row frame of long lines with a one row window.
    task automatic test_long_line();
        set_frame(LONG_LINE_W, 1, 0, 3);
        gap_max = 0;
        stall_pct = 0;
        repeat (LONG_LINE_W) send_item(OP_PIXEL, PIX_W'($urandom));
        drain_frame(0);
    endtask

    task automatic test_random_frames();
        int w, h, sent_at_start;
        bit paused;
        paused = 1'b0;
        sent_at_start = items_sent;
        while (items_sent - sent_at_start < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: begin gap_max = 0; stall_pct = 0; end
                1: begin gap_max = 4; stall_pct = 20; end
                2: begin gap_max = 10; stall_pct = 60; end
                default: begin gap_max = 2; stall_pct = 85; end
            endcase
            // One frame in twelve is cut short and restarted by the next setting.
            if ($urandom_range(0, 11) == 0) begin
                repeat ($urandom_range(1, w * h)) send_item(OP_PIXEL, PIX_W'($urandom));
                continue;
            end
            for (int p = 0; p < w * h; p++) begin
                if ($urandom_range(0, 9) == 0) send_item(OP_DRAIN, PIX_W'($urandom));
                // Hold the stream once until every owed mean has come out.
                if (!paused && p == (w * h) / 2 && owed_means.size() != 0) begin
                    wait_until_drained();
                    paused = 1'b1;
                end
                send_item(OP_PIXEL, PIX_W'($urandom));
            end
            drain_frame(20);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        restart_frame();
        test_extremes_and_drain_rules();
        test_size_clamping();
        test_long_line();
        test_random_frames();
        wait_until_drained();
        $display("Covered %0d items and %0d frames, %0d means checked.",
                 items_sent, frames_done, means_checked);
        $display("Mismatches: %0d, cycles: %0d.", mismatches, cycle_count);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
